/* sv/graph_connected_components_macros.svh */
// Assertion macros shared by the connected-components RTL.
`ifndef GRAPH_CONNECTED_COMPONENTS_MACROS_SVH
`define GRAPH_CONNECTED_COMPONENTS_MACROS_SVH

`ifndef NO_ASSERTIONS
// Checked on every clock edge once reset is released.
`define GCC_CHECK(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Checked on every clock edge, also during reset.
`define GCC_CHECK_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define GCC_CHECK(lbl, prop, msg)
`define GCC_CHECK_ALWAYS(lbl, prop, msg)
`endif

`endif

/* sv/gcc_pkg.sv */
// Types and codes shared by the connected-components block.
package gcc_pkg;

  localparam logic [1:0] ACT_CLEAR = 2'd0;
  localparam logic [1:0] ACT_ADD   = 2'd1;
  localparam logic [1:0] ACT_CMP   = 2'd2;
  localparam logic [1:0] ACT_READ  = 2'd3;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_RANGE = 2'd2;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] from_node;
    logic [7:0] to_node;
    logic       edge_used;
    logic [7:0] entry_index;
  } in_item_t;

  typedef struct packed {
    logic [1:0] status;
    logic [8:0] component_id;
    logic [7:0] node_id;
    logic       last_in_component;
  } out_item_t;

  typedef enum logic [3:0] {
    S_IDLE, S_CSTART, S_DEQ, S_DEQW, S_SCAN_IN, S_SCAN_OUT, S_RD0, S_RD1, S_DONE
  } state_t;

  typedef enum logic [1:0] {
    RES_ADD, RES_CMP, RES_RDERR, RES_RD
  } res_kind_t;

  typedef struct packed {
    logic      load_item;
    logic      edge_clear;
    logic      edge_add;
    logic      cmp_init;
    logic      s_next;
    logic      start_visit;
    logic      comp_close;
    logic      deq_rd;
    logic      cur_load;
    logic      scan_step;
    logic      scan_rst;
    logic      scan_out;
    logic      rd_first;
    logic      rd_second;
    logic      out_load;
    res_kind_t res_kind;
  } cmd_t;

  typedef struct packed {
    logic       s_done;
    logic       s_labeled;
    logic       queue_empty;
    logic       scan_done;
    logic       rd_oob;
    logic       out_free;
  } sts_t;

endpackage

/* sv/graph_connected_components.sv */
// Top level of the breadth-first connected-components labeler.
//
//   channel  direction  handshake           payload
//   in_      input      in_valid/in_stall   in_item_t
//   out_     output     out_valid/out_stall out_item_t
//   cfg_     input      cfg_we              node_count (9 bits)
//
// A read fetches two entries through the one list port (none when out of range),
// and any result may wait on out_stall. During compute each dequeued node scans
// the edge store twice at one edge per cycle through its single read port. Reset
// is synchronous and needs no clearing pass. A result waits in the output
// register while a new item is accepted.
module graph_connected_components import gcc_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_item_t   in_data,
  output logic       out_valid,
  input  logic       out_stall,
  output out_item_t  out_data,
  input  logic       cfg_we,
  input  logic [8:0] cfg_data
);

  cmd_t cmd;
  sts_t sts;

  gcc_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_action (in_data.action),
    .in_stall  (in_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  gcc_datapath #(
    .MAX_NODES (MAX_NODES),
    .MAX_EDGES (MAX_EDGES)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

/* sv/gcc_datapath.sv */
// Datapath: edge store, label bits, discovery list, counters and result register.
`include "graph_connected_components_macros.svh"
module gcc_datapath import gcc_pkg::*; #(
  parameter int MAX_NODES = 256,
  parameter int MAX_EDGES = 1024
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_data,
  input  logic      cfg_we,
  input  logic [8:0] cfg_data,
  input  cmd_t      cmd,
  output sts_t      sts,
  input  logic      out_stall,
  output logic      out_valid,
  output out_item_t out_data
);

  localparam int LIST_DEPTH  = (MAX_NODES < 512) ? MAX_NODES : 512;
  localparam int VALID_DEPTH = (MAX_NODES < 256) ? MAX_NODES : 256;
  localparam int LAW = $clog2(LIST_DEPTH);
  localparam int LW  = $clog2(LIST_DEPTH + 1);
  localparam int VAW = $clog2(VALID_DEPTH);
  localparam int EAW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int ETW = $clog2(MAX_EDGES + 1);
  localparam int CW  = (LW > 9) ? LW + 1 : 10;

  logic [15:0] edge_mem [MAX_EDGES];
  logic [16:0] list_mem [LIST_DEPTH];

  in_item_t         item_r;
  logic [8:0]       node_count_r, n_r, s_r, comps_r;
  logic [ETW-1:0]   edge_total_r, e_r;
  logic             pv_r, add_full_r, out_valid_r;
  logic [15:0]      edge_q_r;
  logic [VALID_DEPTH-1:0] valid_r;
  logic [LW-1:0]    list_len_r, head_r;
  logic [16:0]      list_q_r;
  logic [7:0]       cur_r, ent_node_r;
  logic [8:0]       ent_comp_r;
  out_item_t        out_r;

  logic [7:0]     ef, et, scan_node;
  logic           scan_hit, scan_visit, s_visit, list_room, list_rd, has_next;
  logic [LAW-1:0] list_rd_addr;
  logic [7:0]     s_low;
  logic [CW-1:0]  idx_w;
  out_item_t      res;

  assign ef = edge_q_r[15:8];
  assign et = edge_q_r[7:0];
  assign s_low = s_r[7:0];
  assign list_room = CW'(list_len_r) < CW'(LIST_DEPTH);
  assign idx_w = CW'(item_r.entry_index);
  assign has_next = (idx_w + CW'(1)) < CW'(list_len_r);

  always_comb begin
    if (cmd.scan_out) begin
      scan_hit  = (ef == cur_r);
      scan_node = et;
    end else begin
      scan_hit  = (et == cur_r);
      scan_node = ef;
    end
  end

  // only nodes below n reach a label bit, so the truncated index is exact
  assign scan_visit = cmd.scan_step && pv_r && scan_hit &&
                      ({1'b0, ef} < n_r) && ({1'b0, et} < n_r) &&
                      !valid_r[scan_node[VAW-1:0]];
  assign s_visit = cmd.start_visit;

  assign sts.s_done      = (s_r >= n_r);
  assign sts.s_labeled   = (32'(s_r) < VALID_DEPTH) && valid_r[s_r[VAW-1:0]];
  assign sts.queue_empty = (head_r == list_len_r);
  assign sts.scan_done   = !pv_r && (e_r >= edge_total_r);
  assign sts.rd_oob      = idx_w >= CW'(list_len_r);
  assign sts.out_free    = !out_valid_r || !out_stall;

  always_comb begin
    list_rd = cmd.deq_rd || cmd.rd_first || cmd.rd_second;
    if (cmd.deq_rd)
      list_rd_addr = head_r[LAW-1:0];
    else if (cmd.rd_first)
      list_rd_addr = idx_w[LAW-1:0];
    else
      list_rd_addr = LAW'(idx_w + CW'(1));
  end

  // memories
  always_ff @(posedge clk) begin
    if (cmd.edge_add && in_data.edge_used && (32'(edge_total_r) < MAX_EDGES))
      edge_mem[edge_total_r[EAW-1:0]] <= {in_data.from_node, in_data.to_node};
    if (cmd.scan_step && (e_r < edge_total_r))
      edge_q_r <= edge_mem[e_r[EAW-1:0]];
    if (list_room && s_visit)
      list_mem[list_len_r[LAW-1:0]] <= {s_low, comps_r};
    else if (list_room && scan_visit)
      list_mem[list_len_r[LAW-1:0]] <= {scan_node, comps_r};
    if (list_rd)
      list_q_r <= list_mem[list_rd_addr];
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load_item)
      item_r <= in_data;
    if (cmd.edge_add)
      add_full_r <= in_data.edge_used && (32'(edge_total_r) >= MAX_EDGES);
    if (cmd.cmp_init)
      n_r <= ({1'b0, node_count_r} > 10'(LIST_DEPTH)) ? 9'(LIST_DEPTH) : node_count_r;
    if (cmd.cur_load)
      cur_r <= list_q_r[16:9];
    if (cmd.rd_second) begin
      ent_node_r <= list_q_r[16:9];
      ent_comp_r <= list_q_r[8:0];
    end
    if (cmd.out_load)
      out_r <= res;
  end

  always_comb begin
    res = '0;
    case (cmd.res_kind)
      RES_ADD:   res.status = add_full_r ? ST_FULL : ST_OK;
      RES_CMP:   res.component_id = comps_r;
      RES_RDERR: res.status = ST_RANGE;
      RES_RD: begin
        res.component_id      = ent_comp_r;
        res.node_id           = ent_node_r;
        res.last_in_component = !(has_next && (list_q_r[8:0] == ent_comp_r));
      end
      default: res = '0;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_count_r <= '0;
      edge_total_r <= '0;
      e_r          <= '0;
      pv_r         <= 1'b0;
      valid_r      <= '0;
      list_len_r   <= '0;
      head_r       <= '0;
      s_r          <= '0;
      comps_r      <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      if (cfg_we)
        node_count_r <= cfg_data;
      if (cmd.edge_clear)
        edge_total_r <= '0;
      else if (cmd.edge_add && in_data.edge_used && (32'(edge_total_r) < MAX_EDGES))
        edge_total_r <= edge_total_r + ETW'(1);

      if (cmd.cmp_init) begin
        valid_r    <= '0;
        list_len_r <= '0;
        head_r     <= '0;
        s_r        <= '0;
        comps_r    <= '0;
      end else begin
        if (s_visit) begin
          head_r <= list_len_r;
          if (32'(s_r) < VALID_DEPTH)
            valid_r[s_r[VAW-1:0]] <= 1'b1;
          if (list_room)
            list_len_r <= list_len_r + LW'(1);
        end else if (scan_visit) begin
          valid_r[scan_node[VAW-1:0]] <= 1'b1;
          if (list_room)
            list_len_r <= list_len_r + LW'(1);
        end
        if (cmd.deq_rd)
          head_r <= head_r + LW'(1);
        if (cmd.s_next)
          s_r <= s_r + 9'd1;
        if (cmd.comp_close) begin
          s_r     <= s_r + 9'd1;
          comps_r <= comps_r + 9'd1;
        end
      end

      if (cmd.scan_rst || cmd.cur_load) begin
        e_r  <= '0;
        pv_r <= 1'b0;
      end else if (cmd.scan_step) begin
        if (e_r < edge_total_r) begin
          e_r  <= e_r + ETW'(1);
          pv_r <= 1'b1;
        end else begin
          pv_r <= 1'b0;
        end
      end

      if (cmd.out_load)
        out_valid_r <= 1'b1;
      else if (!out_stall)
        out_valid_r <= 1'b0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `GCC_CHECK(a_head_le_len, CW'(head_r) <= CW'(list_len_r), "queue head passed list end")
  `GCC_CHECK(a_list_bound, CW'(list_len_r) <= CW'(LIST_DEPTH), "discovery list overflow")
  `GCC_CHECK(a_edge_bound, 32'(edge_total_r) <= MAX_EDGES, "edge count overflow")
  `GCC_CHECK(a_one_visit, !(s_visit && scan_visit), "two list appends in one cycle")

endmodule

/* sv/gcc_ctrl.sv */
// Controller: sequences edge loads, breadth-first labeling and list reads.
`include "graph_connected_components_macros.svh"
module gcc_ctrl import gcc_pkg::*; (
  input  logic clk,
  input  logic rst_n,
  input  logic in_valid,
  input  logic [1:0] in_action,
  output logic in_stall,
  input  sts_t sts,
  output cmd_t cmd
);

  state_t    state_r, state_nxt;
  res_kind_t kind_r, kind_nxt;
  logic      accept;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      kind_r  <= RES_ADD;
    end else begin
      state_r <= state_nxt;
      kind_r  <= kind_nxt;
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    kind_nxt     = kind_r;
    cmd          = '0;
    cmd.res_kind = kind_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          cmd.load_item = 1'b1;
          case (in_action)
            ACT_CLEAR: cmd.edge_clear = 1'b1;
            ACT_ADD: begin
              cmd.edge_add = 1'b1;
              kind_nxt     = RES_ADD;
              state_nxt    = S_DONE;
            end
            ACT_CMP: begin
              cmd.cmp_init = 1'b1;
              state_nxt    = S_CSTART;
            end
            default: state_nxt = S_RD0;
          endcase
        end
      end
      S_CSTART: begin
        if (sts.s_done) begin
          kind_nxt  = RES_CMP;
          state_nxt = S_DONE;
        end else if (sts.s_labeled) begin
          cmd.s_next = 1'b1;
        end else begin
          cmd.start_visit = 1'b1;
          state_nxt       = S_DEQ;
        end
      end
      S_DEQ: begin
        if (sts.queue_empty) begin
          cmd.comp_close = 1'b1;
          state_nxt      = S_CSTART;
        end else begin
          cmd.deq_rd = 1'b1;
          state_nxt  = S_DEQW;
        end
      end
      S_DEQW: begin
        cmd.cur_load = 1'b1;
        state_nxt    = S_SCAN_IN;
      end
      S_SCAN_IN: begin
        if (sts.scan_done) begin
          cmd.scan_rst = 1'b1;
          state_nxt    = S_SCAN_OUT;
        end else begin
          cmd.scan_step = 1'b1;
        end
      end
      S_SCAN_OUT: begin
        cmd.scan_out = 1'b1;
        if (sts.scan_done)
          state_nxt = S_DEQ;
        else
          cmd.scan_step = 1'b1;
      end
      S_RD0: begin
        if (sts.rd_oob) begin
          kind_nxt  = RES_RDERR;
          state_nxt = S_DONE;
        end else begin
          cmd.rd_first = 1'b1;
          state_nxt    = S_RD1;
        end
      end
      S_RD1: begin
        // entry latched, next entry fetched for the last-of-component test
        cmd.rd_second = 1'b1;
        kind_nxt      = RES_RD;
        state_nxt     = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  `GCC_CHECK(a_load_from_done, cmd.out_load |-> (state_r == S_DONE), "result outside done")
  `GCC_CHECK(a_accept_idle, accept |=> ($past(state_r) == S_IDLE), "item taken while busy")
  `GCC_CHECK_ALWAYS(a_reset_idle, !rst_n |=> (state_r == S_IDLE), "reset did not idle")

endmodule

/* test/graph_connected_components_tb.sv */
// Self-checking testbench for the breadth-first connected-components labeler.
`timescale 1ns / 100ps

module graph_connected_components_tb import gcc_pkg::*;;

  localparam int NODE_CAP  = 256;
  localparam int EDGE_CAP  = 1024;
  localparam int CYCLE_CAP = 4000000;
  localparam int DRAIN     = 64;
  localparam int HOLD_LEN  = 300;

  logic       clk;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  in_item_t   in_data;
  logic       out_valid;
  logic       out_stall;
  out_item_t  out_data;
  logic       cfg_we;
  logic [8:0] cfg_data;

  graph_connected_components i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_we   (cfg_we),
    .cfg_data (cfg_data)
  );

  // predictor state
  logic [7:0] edge_from [EDGE_CAP];
  logic [7:0] edge_to   [EDGE_CAP];
  int         edge_cnt;
  logic [8:0] node_comp [NODE_CAP];
  bit         node_seen [NODE_CAP];
  logic [7:0] disc_list [NODE_CAP];
  int         disc_len;
  logic [8:0] comp_cnt;
  int         nodes_cfg;

  out_item_t pending_results[$];
  int  err_cnt = 0;
  int  item_cnt;
  int  result_cnt = 0;
  int  label_runs;
  int  cycle_cnt = 0;
  bit  quiet;
  bit  hold_req;

  typedef struct {
    int        cfg;
    in_item_t  it;
    bit        typed;
    out_item_t want;
  } dir_row_t;

  dir_row_t dir_rows[$];

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic in_item_t mk_item(logic [1:0] act, int f, int t, bit used, int idx);
    in_item_t it;
    it.action      = act;
    it.from_node   = f[7:0];
    it.to_node     = t[7:0];
    it.edge_used   = used;
    it.entry_index = idx[7:0];
    return it;
  endfunction

  function automatic out_item_t mk_res(logic [1:0] st, int comp, int node, bit last);
    out_item_t r;
    r.status            = st;
    r.component_id      = comp[8:0];
    r.node_id           = node[7:0];
    r.last_in_component = last;
    return r;
  endfunction

  function automatic void add_row(int cfg, in_item_t it, bit typed, out_item_t want);
    dir_row_t r;
    r.cfg   = cfg;
    r.it    = it;
    r.typed = typed;
    r.want  = want;
    dir_rows = {dir_rows, r};
  endfunction

  function void label_node(int node, int comp);
    if (!node_seen[node]) begin
      node_seen[node] = 1'b1;
      node_comp[node] = comp[8:0];
      disc_list[disc_len] = node[7:0];
      disc_len++;
    end
  endfunction

  function void label_components();
    int n, comps, head, cur, e, s;
    n = (nodes_cfg < NODE_CAP) ? nodes_cfg : NODE_CAP;
    for (s = 0; s < NODE_CAP; s++) node_seen[s] = 1'b0;
    disc_len = 0;
    comps = 0;
    for (s = 0; s < n; s++) begin
      if (!node_seen[s]) begin
        head = disc_len;
        label_node(s, comps);
        while (head < disc_len) begin
          cur = disc_list[head];
          head++;
          // edges into the node first, then edges out of it
          for (e = 0; e < edge_cnt; e++)
            if (edge_to[e] == cur && edge_from[e] < n && edge_to[e] < n)
              label_node(edge_from[e], comps);
          for (e = 0; e < edge_cnt; e++)
            if (edge_from[e] == cur && edge_from[e] < n && edge_to[e] < n)
              label_node(edge_to[e], comps);
        end
        comps++;
      end
    end
    comp_cnt = comps[8:0];
  endfunction

  // updates predictor state; returns 1 when a result is expected
  function bit predict_result(in_item_t it, output out_item_t res);
    int idx;
    res = mk_res(ST_OK, 0, 0, 1'b0);
    idx = it.entry_index;
    case (it.action)
      ACT_CLEAR: begin
        edge_cnt = 0;
        return 1'b0;
      end
      ACT_ADD: begin
        if (it.edge_used) begin
          if (edge_cnt >= EDGE_CAP) begin
            res.status = ST_FULL;
          end else begin
            edge_from[edge_cnt] = it.from_node;
            edge_to[edge_cnt]   = it.to_node;
            edge_cnt++;
          end
        end
      end
      ACT_CMP: begin
        label_components();
        res.component_id = comp_cnt;
      end
      default: begin
        if (idx >= disc_len) begin
          res.status = ST_RANGE;
        end else begin
          res.node_id           = disc_list[idx];
          res.component_id      = node_comp[disc_list[idx]];
          res.last_in_component = 1'b1;
          if (idx + 1 < disc_len && node_comp[disc_list[idx + 1]] == res.component_id)
            res.last_in_component = 1'b0;
        end
      end
    endcase
    return 1'b1;
  endfunction

  task automatic send_item(in_item_t it, bit typed, out_item_t want);
    int gap;
    out_item_t res;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    item_cnt++;
    if (it.action == ACT_CMP) label_runs++;
    if (predict_result(it, res)) begin
      if (typed) res = want;
      pending_results = {pending_results, res};
    end
  endtask

  task automatic send(in_item_t it);
    send_item(it, 1'b0, mk_res(ST_OK, 0, 0, 1'b0));
  endtask

  task automatic set_nodes(int v);
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    // a clear has no result and may still be in flight
    repeat (20) @(posedge clk);
    cfg_we   <= 1'b1;
    cfg_data <= v[8:0];
    @(posedge clk);
    cfg_we   <= 1'b0;
    nodes_cfg = v;
  endtask

  // result receiver: random holds, plus one long hold on request
  initial begin
    int k;
    bit held;
    held = 1'b0;
    out_stall = 1'b1;
    @(posedge rst_n);
    forever begin
      if (hold_req && !held) begin
        held = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_LEN) @(posedge clk);
      end
      k = quiet ? 0 : $urandom_range(0, 11);
      if (k > 0) begin
        out_stall <= 1'b1;
        repeat (k) @(posedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!(out_valid && !out_stall)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    out_item_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      result_cnt++;
      if (pending_results.size() == 0) begin
        $error("unexpected transaction: %p", out_data);
        err_cnt++;
      end else begin
        exp_res = pending_results.pop_front();
        if (out_data.status !== exp_res.status) begin
          $error("status: expected %0d, got %0d", exp_res.status, out_data.status);
          err_cnt++;
        end
        if (out_data.component_id !== exp_res.component_id) begin
          $error("component_id: expected %0d, got %0d",
                 exp_res.component_id, out_data.component_id);
          err_cnt++;
        end
        if (out_data.node_id !== exp_res.node_id) begin
          $error("node_id: expected %0d, got %0d", exp_res.node_id, out_data.node_id);
          err_cnt++;
        end
        if (out_data.last_in_component !== exp_res.last_in_component) begin
          $error("last_in_component: expected %0d, got %0d",
                 exp_res.last_in_component, out_data.last_in_component);
          err_cnt++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt > CYCLE_CAP) begin
      $display("timeout after %0d cycles, %0d results outstanding",
               cycle_cnt, pending_results.size());
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic int pick_node(int n);
    if ($urandom_range(0, 9) == 0) return $urandom_range(0, 255);
    return $urandom_range(0, (n < 2 ? 2 : n) + 1) & 8'hff;
  endfunction

  initial begin
    int i, n, m, r, limit;
    out_item_t none;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_data  = '0;
    item_cnt = 0; label_runs = 0;
    quiet = 1'b0; hold_req = 1'b0;
    edge_cnt = 0; disc_len = 0; comp_cnt = '0; nodes_cfg = 0;
    for (i = 0; i < NODE_CAP; i++) node_seen[i] = 1'b0;
    none = mk_res(ST_OK, 0, 0, 1'b0);

    // directed rows
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 0), 1, mk_res(ST_RANGE, 0, 0, 0));
    add_row(-1, mk_item(ACT_CMP, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 0));
    add_row(256, mk_item(ACT_ADD, 255, 0, 1, 0), 0, none);
    add_row(-1, mk_item(ACT_ADD, 0, 255, 0, 255), 1, mk_res(ST_OK, 0, 0, 0));
    add_row(-1, mk_item(ACT_ADD, 3, 4, 1, 0), 0, none);
    add_row(-1, mk_item(ACT_ADD, 4, 3, 1, 0), 0, none);
    add_row(-1, mk_item(ACT_ADD, 7, 7, 1, 0), 0, none);
    add_row(-1, mk_item(ACT_CMP, 0, 0, 0, 0), 0, none);
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 0), 0, none);
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 255), 0, none);
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 1), 0, none);
    add_row(-1, mk_item(ACT_CLEAR, 0, 0, 0, 0), 0, none);
    add_row(-1, mk_item(ACT_CMP, 255, 255, 1, 255), 1, mk_res(ST_OK, 256, 0, 0));
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 255), 1, mk_res(ST_OK, 255, 255, 1));
    add_row(300, mk_item(ACT_ADD, 200, 100, 1, 0), 0, none);
    add_row(-1, mk_item(ACT_CMP, 0, 0, 0, 0), 0, none);
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 254), 0, none);
    add_row(1, mk_item(ACT_CMP, 0, 0, 0, 0), 1, mk_res(ST_OK, 1, 0, 0));
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 0), 1, mk_res(ST_OK, 0, 0, 1));
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 1), 1, mk_res(ST_RANGE, 0, 0, 0));
    add_row(511, mk_item(ACT_CMP, 0, 0, 0, 0), 0, none);
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 128), 0, none);
    // node count changed after compute: reads still see the old list
    add_row(5, mk_item(ACT_READ, 0, 0, 0, 200), 0, none);
    add_row(-1, mk_item(ACT_CMP, 0, 0, 0, 0), 0, none);
    add_row(-1, mk_item(ACT_READ, 0, 0, 0, 4), 0, none);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[j]) begin
      if (dir_rows[j].cfg >= 0) set_nodes(dir_rows[j].cfg);
      send_item(dir_rows[j].it, dir_rows[j].typed, dir_rows[j].want);
    end

    // fill the edge store past its capacity once, on a tiny graph
    set_nodes(3);
    send(mk_item(ACT_CLEAR, 0, 0, 0, 0));
    for (i = 0; i < EDGE_CAP + 6; i++)
      send(mk_item(ACT_ADD, $urandom_range(0, 255), $urandom_range(0, 3), 1,
                   $urandom_range(0, 255)));
    send(mk_item(ACT_CMP, 0, 0, 0, 0));
    for (i = 0; i < 5; i++) send(mk_item(ACT_READ, 0, 0, 0, i));
    send(mk_item(ACT_CLEAR, 0, 0, 0, 0));

    // random graphs: set size, load edges, label, read back
    for (int ph = 0; item_cnt < 1750; ph++) begin
      r = $urandom_range(0, 19);
      n = (r == 0) ? 256 : (r == 1) ? 511 : (r == 2) ? 0 : (r == 3) ? 1
          : $urandom_range(2, 24);
      set_nodes(n);
      quiet = ($urandom_range(0, 4) == 0);
      if (edge_cnt > 60 || $urandom_range(0, 4) != 0)
        send(mk_item(ACT_CLEAR, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1), $urandom_range(0, 255)));
      m = $urandom_range(0, 30);
      for (i = 0; i < m; i++)
        send(mk_item(ACT_ADD, pick_node(n), pick_node(n), $urandom_range(0, 9) != 0,
                     $urandom_range(0, 255)));
      send(mk_item(ACT_CMP, $urandom_range(0, 255), $urandom_range(0, 255),
                   $urandom_range(0, 1), $urandom_range(0, 255)));
      if (ph == 3) begin
        // long receiver hold while the sender keeps going
        hold_req = 1'b1;
        quiet = 1'b1;
        limit = 40;
      end else begin
        limit = $urandom_range(0, 20);
      end
      for (i = 0; i < limit; i++)
        send(mk_item(ACT_READ, $urandom_range(0, 255), $urandom_range(0, 255),
                     $urandom_range(0, 1),
                     ($urandom_range(0, 4) == 0) ? $urandom_range(0, 255) : pick_node(n)));
      quiet = 1'b0;
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
    $display("Sent %0d transactions and checked %0d results over %0d labeling runs,",
             item_cnt, result_cnt, label_runs);
    $display("including a full edge store, node counts 0 to 511 and a long output hold.");
    if (err_cnt == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

/* sim.f */
+incdir+sv
sv/gcc_pkg.sv
sv/gcc_datapath.sv
sv/gcc_ctrl.sv
sv/graph_connected_components.sv
test/graph_connected_components_tb.sv
